// ===== hw/rtl/tnc_pkg.sv =====
package tnc_pkg;

  localparam int unsigned FREQ_W   = 40;
  localparam int unsigned TICK_W   = 64;
  localparam int unsigned MULT_W   = 32;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned APB_AW   = 3;

  // Dividend of the conversion search: 1e9 scaled by the starting shift.
  localparam int unsigned START_SHIFT = 32;
  localparam int unsigned DIVD_W      = 62;
  localparam logic [DIVD_W-1:0] DIVIDEND = DIVD_W'(64'd1000000000 << START_SHIFT);
  localparam logic [SHIFT_W-1:0] DIV_LAST = SHIFT_W'(DIVD_W - 1);

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(24000000);

  localparam logic [APB_AW-1:0] ADDR_TICK_FREQ = '0;

  typedef enum logic {
    CMD_INIT = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INIT_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 2'd2;

endpackage

// ===== hw/rtl/tick_to_nanosecond_clock.sv =====
// Tick to nanosecond clock. Turns samples of a free-running tick counter into
// monotonic nanoseconds by ns = (ticks * mult) >> shift. An init transaction
// (cmd 0) finds mult and shift for the programmed tick_freq with one bit-serial
// restoring divide of (1e9 << 32) by tick_freq, then walks the quotient
// right one bit per cycle until it fits 32 bits, latches the sample as base
// and returns the converted sample. A read transaction (cmd 1) adds the
// converted delta since the base to the running time, modulo 2^64. The 64x32
// product goes through one shared 32x32 multiplier, low word then high word,
// then a shift-and-merge step and an accumulate step. When tick_freq is zero
// an init runs no divide. in_stall is high for the whole transaction. The
// result sits in an output register, so a pending result does not block the
// next input transaction. Status: 0 ok, 1 init failed (no usable multiplier,
// including tick_freq zero), 2 read before a successful init; both error
// cases return time 0. tick_freq lives at byte address 0 of the APB port,
// 64-bit data, low 40 bits kept; write it only while the block is idle.
module tick_to_nanosecond_clock (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [tnc_pkg::TICK_W-1:0]         in_counter_sample,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tnc_pkg::TICK_W-1:0]         out_time_ns,
  output logic [tnc_pkg::STATUS_W-1:0]       out_status,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tnc_pkg::APB_AW-1:0]         paddr,
  input  logic [tnc_pkg::APB_DW-1:0]         pwdata,
  output logic [tnc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,     // restoring divide, one quotient bit per cycle
    S_NORM,    // halve quotient / decrement shift until it fits 32 bits
    S_MUL_LO,  // low word of ticks times mult
    S_MUL_HI,  // high word of ticks times mult
    S_SCALE,   // merge partial products under the shift
    S_SUM,     // accumulate and update base
    S_OUT      // hand result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [tnc_pkg::FREQ_W-1:0]   tick_freq_r, tick_freq_nxt;
  logic [tnc_pkg::TICK_W-1:0]   base_r, base_nxt;
  logic [tnc_pkg::TICK_W-1:0]   accum_r, accum_nxt;
  logic [tnc_pkg::MULT_W-1:0]   mult_r, mult_nxt;
  logic [tnc_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic                         ready_r, ready_nxt;

  // working registers
  logic                         is_init_r, is_init_nxt;
  logic [tnc_pkg::TICK_W-1:0]   samp_r, samp_nxt;
  logic [tnc_pkg::TICK_W-1:0]   op_r, op_nxt;
  logic [tnc_pkg::DIVD_W-1:0]   dq_r, dq_nxt;      // dividend in, quotient out
  logic [tnc_pkg::FREQ_W-1:0]   rem_r, rem_nxt;
  logic [tnc_pkg::SHIFT_W-1:0]  cnt_r, cnt_nxt;    // divide steps / search shift
  logic [2*tnc_pkg::MULT_W-1:0] plo_r, plo_nxt;
  logic [2*tnc_pkg::MULT_W-1:0] phi_r, phi_nxt;
  logic [tnc_pkg::TICK_W-1:0]   scaled_r, scaled_nxt;
  logic [tnc_pkg::TICK_W-1:0]   res_time_r, res_time_nxt;
  logic [tnc_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [tnc_pkg::TICK_W-1:0]   out_time_r, out_time_nxt;
  logic [tnc_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                         in_acc;
  logic                         cfg_wr;
  logic [tnc_pkg::FREQ_W:0]     rem_sh;
  logic [tnc_pkg::FREQ_W-1:0]   rem_diff;
  logic                         q_bit;
  logic [tnc_pkg::MULT_W-1:0]   mul_a;
  logic [2*tnc_pkg::MULT_W-1:0] mul_p;
  logic [tnc_pkg::SHIFT_W-1:0]  lshift;
  logic [tnc_pkg::TICK_W-1:0]   acc_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_time_ns = out_time_r;
  assign out_status  = out_status_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == tnc_pkg::ADDR_TICK_FREQ);
  assign prdata = (paddr == tnc_pkg::ADDR_TICK_FREQ) ?
                  tnc_pkg::APB_DW'(tick_freq_r) : '0;

  // divider step; when the bit is taken the difference is below tick_freq
  assign rem_sh   = {rem_r, dq_r[tnc_pkg::DIVD_W-1]};
  assign rem_diff = rem_sh[tnc_pkg::FREQ_W-1:0] - tick_freq_r;
  assign q_bit    = (rem_sh >= {1'b0, tick_freq_r});

  // shared multiplier: low word first, then high word
  assign mul_a = (state_r == S_MUL_LO) ? op_r[tnc_pkg::MULT_W-1:0]
                                       : op_r[tnc_pkg::TICK_W-1:tnc_pkg::MULT_W];
  assign mul_p = (2*tnc_pkg::MULT_W)'(mul_a) * (2*tnc_pkg::MULT_W)'(mult_r);

  assign lshift  = tnc_pkg::SHIFT_W'(tnc_pkg::START_SHIFT) - shift_r;
  assign acc_new = is_init_r ? scaled_r : accum_r + scaled_r;

  always_comb begin
    state_nxt      = state_r;
    tick_freq_nxt  = tick_freq_r;
    base_nxt       = base_r;
    accum_nxt      = accum_r;
    mult_nxt       = mult_r;
    shift_nxt      = shift_r;
    ready_nxt      = ready_r;
    is_init_nxt    = is_init_r;
    samp_nxt       = samp_r;
    op_nxt         = op_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    plo_nxt        = plo_r;
    phi_nxt        = phi_r;
    scaled_nxt     = scaled_r;
    res_time_nxt   = res_time_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_time_nxt   = out_time_r;
    out_status_nxt = out_status_r;

    if (cfg_wr) begin
      tick_freq_nxt = pwdata[tnc_pkg::FREQ_W-1:0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          samp_nxt = in_counter_sample;
          if (in_cmd == tnc_pkg::CMD_INIT) begin
            is_init_nxt = 1'b1;
            mult_nxt    = '0;
            shift_nxt   = '0;
            ready_nxt   = 1'b0;
            op_nxt      = in_counter_sample;
            if (tick_freq_r == '0) begin
              res_time_nxt   = '0;
              res_status_nxt = tnc_pkg::ST_INIT_FAIL;
              state_nxt      = S_OUT;
            end else begin
              dq_nxt    = tnc_pkg::DIVIDEND;
              rem_nxt   = '0;
              cnt_nxt   = tnc_pkg::DIV_LAST;
              state_nxt = S_DIV;
            end
          end else begin
            is_init_nxt = 1'b0;
            op_nxt      = in_counter_sample - base_r;
            if (!ready_r) begin
              res_time_nxt   = '0;
              res_status_nxt = tnc_pkg::ST_NOT_INIT;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_MUL_LO;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt = q_bit ? rem_diff : rem_sh[tnc_pkg::FREQ_W-1:0];
        dq_nxt  = {dq_r[tnc_pkg::DIVD_W-2:0], q_bit};
        if (cnt_r == '0) begin
          cnt_nxt   = tnc_pkg::SHIFT_W'(tnc_pkg::START_SHIFT);
          state_nxt = S_NORM;
        end else begin
          cnt_nxt = cnt_r - tnc_pkg::SHIFT_W'(1);
        end
      end
      S_NORM: begin
        // q(s-1) = q(s) >> 1, so the search walks the quotient down
        if (dq_r[tnc_pkg::DIVD_W-1:tnc_pkg::MULT_W] == '0) begin
          if (dq_r[tnc_pkg::MULT_W-1:0] != '0) begin
            mult_nxt  = dq_r[tnc_pkg::MULT_W-1:0];
            shift_nxt = cnt_r;
            ready_nxt = 1'b1;
            state_nxt = S_MUL_LO;
          end else begin
            res_time_nxt   = '0;
            res_status_nxt = tnc_pkg::ST_INIT_FAIL;
            state_nxt      = S_OUT;
          end
        end else if (cnt_r == tnc_pkg::SHIFT_W'(1)) begin
          res_time_nxt   = '0;
          res_status_nxt = tnc_pkg::ST_INIT_FAIL;
          state_nxt      = S_OUT;
        end else begin
          dq_nxt  = dq_r >> 1;
          cnt_nxt = cnt_r - tnc_pkg::SHIFT_W'(1);
        end
      end
      S_MUL_LO: begin
        plo_nxt   = mul_p;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        phi_nxt   = mul_p;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        scaled_nxt = (phi_r << lshift) + (plo_r >> shift_r);
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        accum_nxt      = acc_new;
        base_nxt       = samp_r;
        res_time_nxt   = acc_new;
        res_status_nxt = tnc_pkg::ST_OK;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_time_nxt   = res_time_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_freq_r <= tnc_pkg::FREQ_RESET;
      base_r      <= '0;
      accum_r     <= '0;
      mult_r      <= '0;
      shift_r     <= '0;
      ready_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_freq_r <= tick_freq_nxt;
      base_r      <= base_nxt;
      accum_r     <= accum_nxt;
      mult_r      <= mult_nxt;
      shift_r     <= shift_nxt;
      ready_r     <= ready_nxt;
    end
    // payload, no reset
    is_init_r    <= is_init_nxt;
    samp_r       <= samp_nxt;
    op_r         <= op_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    plo_r        <= plo_nxt;
    phi_r        <= phi_nxt;
    scaled_r     <= scaled_nxt;
    res_time_r   <= res_time_nxt;
    res_status_r <= res_status_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== hw/rtl/tnc_checker.sv =====
module tnc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tnc_pkg::TICK_W-1:0]   out_time_ns,
  input logic [tnc_pkg::STATUS_W-1:0] out_status
);

  // the block is still busy in the cycle after it accepts a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a transaction back to back");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tnc_pkg::ST_OK || out_status == tnc_pkg::ST_INIT_FAIL ||
                   out_status == tnc_pkg::ST_NOT_INIT))
    else $error("undefined status code");

  // error results carry zero time
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tnc_pkg::ST_OK |-> out_time_ns == '0)
    else $error("error result with nonzero time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time_ns) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind tick_to_nanosecond_clock tnc_checker u_tnc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_time_ns (out_time_ns),
  .out_status  (out_status)
);
